### sv/pip_pkg.sv
package pip_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int MIN_POLY_VERTICES = 3;
   localparam int COORD_W = 16;
   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int ADDR_W = 3;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic REG_RAY_END = 1'b0;

   localparam logic [1:0] ORI_COL = 2'd0;
   localparam logic [1:0] ORI_POS = 2'd1;
   localparam logic [1:0] ORI_NEG = 2'd2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [CROSS_W-1:0] cross_type;
   typedef logic [1:0] ori_type;

   localparam coord_type RAY_END_RESET = COORD_W'(9999);

   // Query state that walks down the cell row, plus the partial results
   // of the edge evaluated in the previous cell.
   typedef struct packed {
      logic      valid;
      coord_type qx;
      coord_type qy;
      logic      hits;
      logic      done;
      logic      res;
      logic      pend;
      prod_type  p1;
      prod_type  p2;
      prod_type  p3;
      ori_type   d3;
      ori_type   d4;
      logic      box_q;
      logic      box_f;
      logic      box_a;
      logic      box_b;
   } token_type;

   function automatic logic pip_in_box(coord_type ax, coord_type ay, coord_type bx,
                                       coord_type by, coord_type px, coord_type py);
      return (px <= ax || px <= bx) && (px >= ax || px >= bx) &&
             (py <= ay || py <= by) && (py >= ay || py >= by);
   endfunction

   function automatic ori_type pip_ori(cross_type v);
      if (v == '0) begin
         return ORI_COL;
      end
      return v[CROSS_W-1] ? ORI_NEG : ORI_POS;
   endfunction

   // Orientation against the horizontal ray: sign of -(u * w).
   function automatic ori_type pip_side(diff_type u, diff_type w);
      if (u == '0 || w == '0) begin
         return ORI_COL;
      end
      return (u[DIFF_W-1] ^ w[DIFF_W-1]) ? ORI_POS : ORI_NEG;
   endfunction

   function automatic token_type pip_resolve(token_type t);
      cross_type v1;
      cross_type v2;
      ori_type   d1;
      ori_type   d2;
      logic      meet;
      token_type r;
      r = t;
      v1 = CROSS_W'(t.p1) - CROSS_W'(t.p2);
      v2 = CROSS_W'(t.p3) - CROSS_W'(t.p2);
      d1 = pip_ori(v1);
      d2 = pip_ori(v2);
      meet = (d1 != d2 && t.d3 != t.d4) || (d1 == ORI_COL && t.box_q) ||
             (d2 == ORI_COL && t.box_f) || (t.d3 == ORI_COL && t.box_a) ||
             (t.d4 == ORI_COL && t.box_b);
      if (t.valid && t.pend && !t.done && meet) begin
         if (d1 == ORI_COL) begin
            r.done = 1'b1;
            r.res = t.box_q;
         end else begin
            r.hits = ~t.hits;
         end
      end
      r.pend = 1'b0;
      return r;
   endfunction

endpackage

### sv/pip_cell.sv
module pip_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  pip_pkg::coord_type wr_x,
   input  pip_pkg::coord_type wr_y,
   input  pip_pkg::coord_type nxt_x,
   input  pip_pkg::coord_type nxt_y,
   input  pip_pkg::coord_type ray_x,
   input  logic               active,
   input  pip_pkg::token_type tok_prev,
   output pip_pkg::coord_type vx,
   output pip_pkg::coord_type vy,
   output pip_pkg::token_type tok_out
);
   import pip_pkg::*;

   coord_type vx_ff, vy_ff;
   token_type tok_ff, tok_in;
   diff_type  dy_ab, dx_ab, dx_qb, dy_qb, dx_rb, u_rq, w_a, w_b;

   // Finish the previous cell's edge, then start this cell's edge.
   always_comb begin
      dy_ab = DIFF_W'(nxt_y) - DIFF_W'(vy_ff);
      dx_ab = DIFF_W'(nxt_x) - DIFF_W'(vx_ff);
      dx_qb = DIFF_W'(tok_prev.qx) - DIFF_W'(nxt_x);
      dy_qb = DIFF_W'(tok_prev.qy) - DIFF_W'(nxt_y);
      dx_rb = DIFF_W'(ray_x) - DIFF_W'(nxt_x);
      u_rq = DIFF_W'(ray_x) - DIFF_W'(tok_prev.qx);
      w_a = DIFF_W'(vy_ff) - DIFF_W'(tok_prev.qy);
      w_b = DIFF_W'(nxt_y) - DIFF_W'(tok_prev.qy);
      tok_in = pip_resolve(tok_prev);
      tok_in.pend = tok_prev.valid && active;
      tok_in.p1 = PROD_W'(dy_ab) * PROD_W'(dx_qb);
      tok_in.p2 = PROD_W'(dx_ab) * PROD_W'(dy_qb);
      tok_in.p3 = PROD_W'(dy_ab) * PROD_W'(dx_rb);
      tok_in.d3 = pip_side(u_rq, w_a);
      tok_in.d4 = pip_side(u_rq, w_b);
      tok_in.box_q = pip_in_box(vx_ff, vy_ff, nxt_x, nxt_y, tok_prev.qx, tok_prev.qy);
      tok_in.box_f = pip_in_box(vx_ff, vy_ff, nxt_x, nxt_y, ray_x, tok_prev.qy);
      tok_in.box_a = pip_in_box(tok_prev.qx, tok_prev.qy, ray_x, tok_prev.qy, vx_ff, vy_ff);
      tok_in.box_b = pip_in_box(tok_prev.qx, tok_prev.qy, ray_x, tok_prev.qy, nxt_x, nxt_y);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vx_ff <= wr_x;
         vy_ff <= wr_y;
      end
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign vx = vx_ff;
   assign vy = vy_ff;
   assign tok_out = tok_ff;

endmodule

### sv/point_in_polygon_test.sv
// Point-in-polygon test by horizontal ray casting.
//
// Input beats on req_* carry an opcode and a coordinate pair: clear the
// polygon, append a vertex, or test a query point. Every accepted beat
// yields exactly one result beat on rsp_* with the inside flag, the
// store-full status and the number of vertices held afterwards.
//
// Vertices live in a row of MAX_VERTICES cells, one vertex per cell. A
// query travels down the row one cell per cycle; each cell starts the test
// of its own closing edge and finishes the test of its neighbor's, so a
// query with three or more vertices passes every cell register, then the
// holding and output registers; clear, append and short queries pass only
// the latter two. The row length sets the query time; one item is worked
// at a time: a new beat is accepted once the last leaves the holding register.
//
// A finished result waits in a holding register and then in the output
// register, so the next item is accepted while rsp is stalled; req_stall
// rises only while a query walks the row or the holding register is full.
// Reset empties the polygon, drops any result in flight and sets ray_end_x
// to 9999. ray_end_x is written through the APB-style port at any address with paddr[2] clear.
module point_in_polygon_test (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_opcode,
   input  pip_pkg::coord_type           req_x_coord,
   input  pip_pkg::coord_type           req_y_coord,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_inside_res,
   output logic                         rsp_status,
   output logic [pip_pkg::CNT_W-1:0]    rsp_vertex_total,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [pip_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import pip_pkg::*;

   logic             busy_ff;
   logic [CNT_W-1:0] count_ff;
   coord_type        ray_ff;
   logic             pend_v_ff, pend_inside_ff, pend_status_ff;
   logic [CNT_W-1:0] pend_total_ff;
   logic             rsp_valid_ff, rsp_inside_ff, rsp_status_ff;
   logic [CNT_W-1:0] rsp_total_ff;

   logic      accept;
   logic      cfg_wr;
   token_type tok_w [MAX_VERTICES+1];
   coord_type vx_w [MAX_VERTICES];
   coord_type vy_w [MAX_VERTICES];
   token_type fin;

   assign req_stall = busy_ff || pend_v_ff;
   assign accept = req_valid && !req_stall;
   assign cfg_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_RAY_END) ? 32'(ray_ff) : 32'd0;

   // A query enters the first cell on the beat it is accepted.
   always_comb begin
      tok_w[0] = '0;
      tok_w[0].valid = accept && req_opcode == OP_QUERY &&
                       count_ff >= CNT_W'(MIN_POLY_VERTICES);
      tok_w[0].qx = req_x_coord;
      tok_w[0].qy = req_y_coord;
   end

   for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
      logic      wr_en;
      logic      last;
      coord_type nxt_x, nxt_y;
      assign wr_en = accept && req_opcode == OP_APPEND && count_ff == CNT_W'(i);
      // The last held vertex closes the polygon back to the first one.
      assign last = (i == MAX_VERTICES - 1) || count_ff == CNT_W'(i + 1);
      assign nxt_x = last ? vx_w[0] : vx_w[(i + 1) % MAX_VERTICES];
      assign nxt_y = last ? vy_w[0] : vy_w[(i + 1) % MAX_VERTICES];
      pip_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (wr_en),
         .wr_x     (req_x_coord),
         .wr_y     (req_y_coord),
         .nxt_x    (nxt_x),
         .nxt_y    (nxt_y),
         .ray_x    (ray_ff),
         .active   (count_ff > CNT_W'(i)),
         .tok_prev (tok_w[i]),
         .vx       (vx_w[i]),
         .vy       (vy_w[i]),
         .tok_out  (tok_w[i+1])
      );
   end

   // The final cell's edge is finished here.
   assign fin = pip_resolve(tok_w[MAX_VERTICES]);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         count_ff <= '0;
         ray_ff <= RAY_END_RESET;
         pend_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_wr && paddr[2] == REG_RAY_END) begin
            ray_ff <= pwdata[COORD_W-1:0];
         end
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_valid_ff <= pend_v_ff;
            rsp_inside_ff <= pend_inside_ff;
            rsp_status_ff <= pend_status_ff;
            rsp_total_ff <= pend_total_ff;
            pend_v_ff <= 1'b0;
         end
         if (accept) begin
            pend_inside_ff <= 1'b0;
            pend_status_ff <= 1'b0;
            pend_total_ff <= count_ff;
            pend_v_ff <= 1'b1;
            unique case (req_opcode)
               OP_CLEAR: begin
                  count_ff <= '0;
                  pend_total_ff <= '0;
               end
               OP_APPEND: begin
                  if (count_ff < CNT_W'(MAX_VERTICES)) begin
                     count_ff <= count_ff + 1'b1;
                     pend_total_ff <= count_ff + 1'b1;
                  end else begin
                     pend_status_ff <= 1'b1;
                  end
               end
               OP_QUERY: begin
                  if (count_ff >= CNT_W'(MIN_POLY_VERTICES)) begin
                     busy_ff <= 1'b1;
                     pend_v_ff <= 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         if (fin.valid) begin
            busy_ff <= 1'b0;
            pend_v_ff <= 1'b1;
            pend_inside_ff <= fin.done ? fin.res : fin.hits;
            pend_status_ff <= 1'b0;
            pend_total_ff <= count_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_vertex_total = rsp_total_ff;

endmodule
